FILE: rtl/bfh_pkg.sv
`timescale 1ns / 1ps
package bfh_pkg;

  localparam int unsigned MAX_BITS_DEF   = 65536;
  localparam int unsigned MAX_PROBES_DEF = 16;

  localparam logic [63:0] FNV_BASIS  = 64'hCBF29CE484222325;
  localparam logic [63:0] SEED_TWEAK = 64'h0000DEADBEEFCAFE;
  // The 64-bit prime is 2^40 + 0x1B3.
  localparam logic [8:0]  FNV_PRIME_LO  = 9'h1B3;
  localparam int unsigned FNV_PRIME_SH  = 40;

  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 17;
  localparam logic [CFG_IDX_W-1:0] CFG_BIT_COUNT  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HASH_COUNT = 8'd1;

  localparam int unsigned CNT_W     = 32;
  localparam int unsigned SETBITS_W = 17;

  // Dividend bits consumed per cycle by the remainder unit.
  localparam int unsigned DIV_BITS  = 4;
  localparam int unsigned DIV_STEPS = 64 / DIV_BITS;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

  typedef struct packed {
    logic absorb;
    logic reseed;
  } hash_ctl_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } store_ctl_t;

  function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
    logic [63:0] x;
    x = h ^ {56'd0, b};
    return (x << FNV_PRIME_SH) + x * {55'd0, FNV_PRIME_LO};
  endfunction

endpackage

FILE: rtl/bfh_hash.sv
`timescale 1ns / 1ps
module bfh_hash
  import bfh_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  hash_ctl_t   ctl_i,
  input  logic [7:0]  byte_i,
  output logic [63:0] h1_o,
  output logic [63:0] h2_o
);

  logic [63:0] h1_q, h1_d, h2_q, h2_d;

  always_comb begin
    h1_d = h1_q;
    h2_d = h2_q;
    if (ctl_i.reseed) begin
      h1_d = FNV_BASIS;
      h2_d = FNV_BASIS ^ SEED_TWEAK;
    end else if (ctl_i.absorb) begin
      h1_d = fnv_step(h1_q, byte_i);
      h2_d = fnv_step(h2_q, byte_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h1_q <= FNV_BASIS;
      h2_q <= FNV_BASIS ^ SEED_TWEAK;
    end else begin
      h1_q <= h1_d;
      h2_q <= h2_d;
    end
  end

  assign h1_o = h1_q;
  assign h2_o = h2_q;

endmodule

FILE: rtl/bfh_mod.sv
`timescale 1ns / 1ps
module bfh_mod
  import bfh_pkg::*;
#(
  parameter int unsigned MW = 17
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [63:0]   dividend_i,
  input  logic [MW-1:0] modulus_i,
  output logic          done_o,
  output logic [MW-1:0] rem_o
);

  logic [MW-1:0]        rem_q, rem_d;
  logic [63:0]          sh_q, sh_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                 busy_q, busy_d, done_q, done_d;
  logic [MW:0]          t;

  // Restoring remainder, several dividend bits per cycle, MSB first.
  always_comb begin
    rem_d  = rem_q;
    sh_d   = sh_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    t      = '0;
    if (start_i) begin
      rem_d  = '0;
      sh_d   = dividend_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      for (int j = 0; j < DIV_BITS; j++) begin
        t = {rem_d, sh_d[63]};
        if (t >= {1'b0, modulus_i}) t = t - {1'b0, modulus_i};
        rem_d = t[MW-1:0];
        sh_d  = {sh_d[62:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    sh_q  <= sh_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

FILE: rtl/bfh_store.sv
`timescale 1ns / 1ps
module bfh_store
  import bfh_pkg::*;
#(
  parameter int unsigned MAX_BITS = MAX_BITS_DEF,
  localparam int unsigned AW = $clog2(MAX_BITS)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  store_ctl_t    ctl_i,
  input  logic [AW-1:0] addr_i,
  output logic          rd_data_o,
  output logic          clearing_o
);

  logic            mem [MAX_BITS];
  logic            rd_q;
  logic            clr_q, clr_d;
  logic [AW-1:0]   clr_addr_q, clr_addr_d;

  // After reset the array is swept to zero, one entry per cycle.
  always_comb begin
    clr_d      = clr_q;
    clr_addr_d = clr_addr_q;
    if (clr_q) begin
      clr_addr_d = clr_addr_q + 1'b1;
      if (clr_addr_q == AW'(MAX_BITS - 1)) clr_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      clr_q      <= clr_d;
      clr_addr_q <= clr_addr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_q) begin
      mem[clr_addr_q] <= 1'b0;
    end else if (ctl_i.wr_en) begin
      mem[addr_i] <= 1'b1;
    end
    if (ctl_i.rd_en) rd_q <= mem[addr_i];
  end

  assign rd_data_o  = rd_q;
  assign clearing_o = clr_q;

endmodule

FILE: rtl/bloom_filter_fnv1a_double_hash.sv
`timescale 1ns / 1ps
// Bloom filter over byte-string keys with two FNV-1a 64-bit hashes.
// Input stream: one key byte per item in s_axis_tdata, s_axis_tlast on the
// final byte, s_axis_tuser[0] = mode (1 insert, 0 query), s_axis_tuser[1]
// = empty key (ends the key without a byte). Only the key-ending item
// produces a result item on m_axis. Registers are written on the cfg
// channel: index 0 bit_count, index 1 hash_count; they are sampled when a
// key ends.
// A middle byte is absorbed into both hashes as it is taken. At a key end,
// each of the k probes reduces a 64-bit position modulo bit_count in the
// remainder unit, four bits per cycle, then reads and updates the bit
// array through its single port.
// After reset the bit array is cleared by a sweep over all MAX_BITS entries,
// during which s_axis_tready stays low; cfg writes are taken at all times.
// The result waits in an output register; while it is stalled, middle bytes
// are still taken, and the next key end finishes its probes and then waits.
module bloom_filter_fnv1a_double_hash
  import bfh_pkg::*;
#(
  parameter int unsigned MAX_BITS   = MAX_BITS_DEF,
  parameter int unsigned MAX_PROBES = MAX_PROBES_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [7:0]            s_axis_tdata,  // key_byte
  input  logic                  s_axis_tlast,  // last_byte
  input  logic [1:0]            s_axis_tuser,  // mode, empty_key
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [55:0]           m_axis_tdata,  // found, inserted_total, set_bits, zero pad
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned AW = $clog2(MAX_BITS);
  localparam int unsigned MW = $clog2(MAX_BITS + 1);
  localparam int unsigned KW = $clog2(MAX_PROBES + 1);

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_PREP  = 6'b000100,
    ST_DIV   = 6'b001000,
    ST_READ  = 6'b010000,
    ST_DONE  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [16:0]          bit_count_q, bit_count_d;
  logic [4:0]           hash_count_q, hash_count_d;
  logic [MW-1:0]        m_q, m_d;
  logic [KW-1:0]        k_q, k_d, i_q, i_d;
  logic                 mode_q, mode_d, found_q, found_d;
  logic [63:0]          pos_q, pos_d;
  logic [CNT_W-1:0]     ins_q, ins_d;
  logic [SETBITS_W-1:0] setc_q, setc_d;
  logic                 ov_q, ov_d;
  logic [55:0]          od_q, od_d;

  hash_ctl_t   hctl;
  store_ctl_t  sctl;
  logic [63:0] h1, h2;
  logic        div_start, div_done;
  logic [63:0] div_arg;
  logic [MW-1:0] rem;
  logic        rd_bit, clearing, in_acc, key_end;
  logic [CNT_W-1:0] ins_nx;

  bfh_hash u_hash (
    .clk_i, .rst_ni, .ctl_i(hctl), .byte_i(s_axis_tdata), .h1_o(h1), .h2_o(h2)
  );

  bfh_mod #(.MW(MW)) u_mod (
    .clk_i, .rst_ni, .start_i(div_start), .dividend_i(div_arg),
    .modulus_i(m_q), .done_o(div_done), .rem_o(rem)
  );

  bfh_store #(.MAX_BITS(MAX_BITS)) u_store (
    .clk_i, .rst_ni, .ctl_i(sctl), .addr_i(rem[AW-1:0]),
    .rd_data_o(rd_bit), .clearing_o(clearing)
  );

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign key_end       = s_axis_tuser[1] || s_axis_tlast;
  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = od_q;

  always_comb begin
    bit_count_d  = bit_count_q;
    hash_count_d = hash_count_q;
    if (cfg_valid_i) begin
      if (cfg_index_i == CFG_BIT_COUNT)  bit_count_d  = cfg_data_i;
      if (cfg_index_i == CFG_HASH_COUNT) hash_count_d = cfg_data_i[4:0];
    end
  end

  always_comb begin
    state_d   = state_q;
    m_d       = m_q;
    k_d       = k_q;
    i_d       = i_q;
    mode_d    = mode_q;
    found_d   = found_q;
    pos_d     = pos_q;
    ins_d     = ins_q;
    setc_d    = setc_q;
    ov_d      = ov_q && !m_axis_tready;
    od_d      = od_q;
    hctl      = '0;
    sctl      = '0;
    div_start = 1'b0;
    div_arg   = pos_q;
    ins_nx    = ins_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (!clearing) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_acc) begin
          hctl.absorb = !s_axis_tuser[1];
          if (key_end) begin
            mode_d  = s_axis_tuser[0];
            found_d = 1'b1;
            i_d     = '0;
            if (bit_count_q == 17'd0) begin
              m_d = MW'(1);
            end else if (32'(bit_count_q) > 32'(MAX_BITS)) begin
              m_d = MW'(MAX_BITS);
            end else begin
              m_d = MW'(bit_count_q);
            end
            if (32'(hash_count_q) > 32'(MAX_PROBES)) k_d = KW'(MAX_PROBES);
            else k_d = KW'(hash_count_q);
            state_d = ST_PREP;
          end
        end
      end
      ST_PREP: begin
        pos_d = h1;
        if (k_q == '0) begin
          state_d = ST_DONE;
        end else begin
          div_start = 1'b1;
          div_arg   = h1;
          state_d   = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          sctl.rd_en = 1'b1;
          state_d    = ST_READ;
        end
      end
      ST_READ: begin
        // Bit of this probe is on rd_bit; the next probe reads it back no
        // earlier than a full remainder pass later.
        if (!rd_bit) begin
          if (mode_q) begin
            sctl.wr_en = 1'b1;
            if (setc_q != '1) setc_d = setc_q + 1'b1;
          end else begin
            found_d = 1'b0;
          end
        end
        i_d   = i_q + 1'b1;
        pos_d = pos_q + h2;
        if (i_d == k_q) begin
          state_d = ST_DONE;
        end else begin
          div_start = 1'b1;
          div_arg   = pos_d;
          state_d   = ST_DIV;
        end
      end
      ST_DONE: begin
        if (!ov_q || m_axis_tready) begin
          if (mode_q && ins_q != '1) ins_nx = ins_q + 1'b1;
          ins_d       = ins_nx;
          ov_d        = 1'b1;
          od_d        = {6'd0, setc_q, ins_nx, mode_q | found_q};
          hctl.reseed = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      bit_count_q  <= 17'd65536;
      hash_count_q <= 5'd7;
      ins_q        <= '0;
      setc_q       <= '0;
      ov_q         <= 1'b0;
    end else begin
      state_q      <= state_d;
      bit_count_q  <= bit_count_d;
      hash_count_q <= hash_count_d;
      ins_q        <= ins_d;
      setc_q       <= setc_d;
      ov_q         <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_q     <= m_d;
    k_q     <= k_d;
    i_q     <= i_d;
    mode_q  <= mode_d;
    found_q <= found_d;
    pos_q   <= pos_d;
    od_q    <= od_d;
  end

endmodule

FILE: rtl/bfh_checker.sv
`timescale 1ns / 1ps
module bfh_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [55:0] m_axis_tdata
);

  logic        seen_q;
  logic [31:0] ins_q;
  logic [16:0] set_q;
  logic        out_acc;

  assign out_acc = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= 1'b0;
      ins_q  <= '0;
      set_q  <= '0;
    end else if (out_acc) begin
      seen_q <= 1'b1;
      ins_q  <= m_axis_tdata[32:1];
      set_q  <= m_axis_tdata[49:33];
    end
  end

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result item changed while stalled");

  a_ins_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && seen_q |-> m_axis_tdata[32:1] == ins_q || m_axis_tdata[32:1] == ins_q + 32'd1)
    else $error("inserted count moved by more than one key");

  a_set_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && seen_q |-> m_axis_tdata[49:33] >= set_q)
    else $error("set bit count decreased");

endmodule

bind bloom_filter_fnv1a_double_hash bfh_checker u_bfh_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);
